/* rtl/chgw_pkg.sv */
// shared constants, types and state encoding for the gift-wrap hull core
`default_nettype none
package chgw_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_BITS_DEF  = 16;
  localparam int VIDX_W          = 6;
  localparam int MIN_HULL_POINTS = 3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMPTY,
    ST_SEEK,
    ST_SCAN,
    ST_RECORD,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  // controls for the candidate evaluation unit
  typedef struct packed {
    logic init;
    logic ph0;
    logic ph1;
    logic ph2;
  } eval_ctl_t;

endpackage
`default_nettype wire

/* rtl/chgw_cell.sv */
// one cell of the point ring: holds a point and its load index
`default_nettype none
module chgw_cell
  import chgw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IW = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         shift,
  input  wire logic                         clear,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  input  wire logic [IW-1:0]                in_idx,
  output logic                              valid,
  output logic signed [COORD_BITS-1:0]      x,
  output logic signed [COORD_BITS-1:0]      y,
  output logic [IW-1:0]                     idx
);

  // valid bit, cleared between sets
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= in_valid;
    end
  end

  // payload moves with the ring
  always_ff @(posedge clk) begin
    if (shift) begin
      x   <= in_x;
      y   <= in_y;
      idx <= in_idx;
    end
  end

endmodule
`default_nettype wire

/* rtl/chgw_eval.sv */
// candidate evaluation: orientation and distance test against the current best
`default_nettype none
module chgw_eval
  import chgw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IW = 6
) (
  input  wire logic                         clk,
  input  wire eval_ctl_t                    ctl,
  input  wire logic                         head_valid,
  input  wire logic signed [COORD_BITS-1:0] head_x,
  input  wire logic signed [COORD_BITS-1:0] head_y,
  input  wire logic [IW-1:0]                head_idx,
  input  wire logic signed [COORD_BITS-1:0] org_x,
  input  wire logic signed [COORD_BITS-1:0] org_y,
  output logic [IW-1:0]                     best_idx,
  output logic signed [COORD_BITS-1:0]      best_x,
  output logic signed [COORD_BITS-1:0]      best_y
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic                         cv;
  logic [IW-1:0]                ci;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [DW-1:0]         dcx, dcy, dbx, dby;
  logic signed [PW-1:0]         p1, p2, p3, p4, p5, p6;
  logic signed [SW-1:0]         cr, cd, bd;
  logic                         take;

  // final compare: candidate strictly right of the origin-to-best line, or collinear and farther
  always_comb begin
    cr   = SW'(p1) - SW'(p2);
    cd   = SW'(p3) + SW'(p4);
    bd   = SW'(p5) + SW'(p6);
    take = cv && ((cr > 0) || ((cr == 0) && (cd > bd)));
  end

  // three-phase evaluation pipeline
  always_ff @(posedge clk) begin
    if (ctl.ph0) begin
      cv  <= head_valid;
      ci  <= head_idx;
      cx  <= head_x;
      cy  <= head_y;
      dcx <= DW'(head_x) - DW'(org_x);
      dcy <= DW'(head_y) - DW'(org_y);
      dbx <= DW'(best_x) - DW'(org_x);
      dby <= DW'(best_y) - DW'(org_y);
    end
    if (ctl.ph1) begin
      p1 <= PW'(dcx) * PW'(dby);
      p2 <= PW'(dcy) * PW'(dbx);
      p3 <= PW'(dcx) * PW'(dcx);
      p4 <= PW'(dcy) * PW'(dcy);
      p5 <= PW'(dbx) * PW'(dbx);
      p6 <= PW'(dby) * PW'(dby);
    end
  end

  // best candidate register
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      best_idx <= head_idx;
      best_x   <= head_x;
      best_y   <= head_y;
    end else if (ctl.ph2 && take) begin
      best_idx <= ci;
      best_x   <= cx;
      best_y   <= cy;
    end
  end

endmodule
`default_nettype wire

/* rtl/convex_hull_gift_wrap_core.sv */
// top level: point ring, wrap sequencer, hull vertex buffer and result port
//
// Loads 2-D points one word per start pulse (start high while busy low).
// The word with last_point set closes the set; busy then rises and the
// core gift-wraps the hull. Points sit in a ring of MAX_POINTS cells that
// rotates past one evaluation unit at the head cell. For each hull vertex
// the ring first rotates until the vertex's scan start reaches the head,
// then one full turn of scan passes every cell through the evaluation
// unit in phases ph0, ph1 and ph2. Hull vertices go to a small buffer, then
// stream out one per cycle with strobe high for exactly one cycle each;
// the final one carries last_vertex. With fewer than three points a single
// word with empty_hull comes out after the closing word. The receiver
// cannot stall; results are never held. Reset clears the ring valid bits,
// the point count and the sequencer; the ring is ready for points in the
// cycle after reset.
`default_nettype none
module convex_hull_gift_wrap_core
  import chgw_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic                         last_point,
  output logic                              strobe,
  output logic signed [COORD_BITS-1:0]      hull_x,
  output logic signed [COORD_BITS-1:0]      hull_y,
  output logic [VIDX_W-1:0]                 vertex_index,
  output logic                              last_vertex,
  output logic                              empty_hull,
  output logic                              overflow
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [CW-1:0]                count;
  logic                         dropped;
  logic [IW-1:0]                start_idx;
  logic signed [COORD_BITS-1:0] sx, sy;
  logic [IW-1:0]                cur;
  logic signed [COORD_BITS-1:0] ox, oy;
  logic [IW-1:0]                target;
  logic [IW-1:0]                step;
  logic [1:0]                   phase;
  logic [CW-1:0]                k;
  logic                         wrap;
  logic [IW-1:0]                rd_ptr;

  logic                         accept, load_shift, rotate, clear_cells, match;
  logic                         scan_done, emit_done;
  eval_ctl_t                    ectl;

  logic [IW-1:0]                best_idx;
  logic signed [COORD_BITS-1:0] best_x, best_y;
  logic [IW-1:0]                next_of_start, next_of_best;

  // ring cells
  logic                         c_valid [MAX_POINTS];
  logic signed [COORD_BITS-1:0] c_x     [MAX_POINTS];
  logic signed [COORD_BITS-1:0] c_y     [MAX_POINTS];
  logic [IW-1:0]                c_idx   [MAX_POINTS];
  logic                         t_valid;
  logic signed [COORD_BITS-1:0] t_x, t_y;
  logic [IW-1:0]                t_idx;

  // hull vertex buffer
  logic [IW-1:0]                m_idx [MAX_POINTS];
  logic [COORD_BITS-1:0]        m_x   [MAX_POINTS];
  logic [COORD_BITS-1:0]        m_y   [MAX_POINTS];
  logic [IW-1:0]                rd_idx;
  logic [COORD_BITS-1:0]        rd_x, rd_y;
  logic                         last_r, empty_r, ovf_r;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign match  = c_valid[0] && (c_idx[0] == target);

  // successor index modulo the point count
  assign next_of_start = ((CW'(start_idx) + 1'b1) == count) ? '0 : IW'(start_idx + 1'b1);
  assign next_of_best  = ((CW'(best_idx) + 1'b1) == count) ? '0 : IW'(best_idx + 1'b1);

  assign scan_done = (phase == 2'd2) && (step == IW'(MAX_POINTS - 1));
  assign emit_done = ((CW'(rd_ptr) + 1'b1) == k);

  // tail of the ring takes a new point while loading, else the head
  always_comb begin
    if (load_shift) begin
      t_valid = 1'b1;
      t_x     = point_x;
      t_y     = point_y;
      t_idx   = IW'(count);
    end else begin
      t_valid = c_valid[0];
      t_x     = c_x[0];
      t_y     = c_y[0];
      t_idx   = c_idx[0];
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    if (i == MAX_POINTS - 1) begin : g_tail
      chgw_cell #(.COORD_BITS(COORD_BITS), .IW(IW)) u_cell (
        .clk(clk), .rst(rst), .shift(load_shift || rotate), .clear(clear_cells),
        .in_valid(t_valid), .in_x(t_x), .in_y(t_y), .in_idx(t_idx),
        .valid(c_valid[i]), .x(c_x[i]), .y(c_y[i]), .idx(c_idx[i])
      );
    end else begin : g_mid
      chgw_cell #(.COORD_BITS(COORD_BITS), .IW(IW)) u_cell (
        .clk(clk), .rst(rst), .shift(load_shift || rotate), .clear(clear_cells),
        .in_valid(c_valid[i+1]), .in_x(c_x[i+1]), .in_y(c_y[i+1]),
        .in_idx(c_idx[i+1]),
        .valid(c_valid[i]), .x(c_x[i]), .y(c_y[i]), .idx(c_idx[i])
      );
    end
  end

  chgw_eval #(.COORD_BITS(COORD_BITS), .IW(IW)) u_eval (
    .clk(clk), .ctl(ectl),
    .head_valid(c_valid[0]), .head_x(c_x[0]), .head_y(c_y[0]), .head_idx(c_idx[0]),
    .org_x(ox), .org_y(oy),
    .best_idx(best_idx), .best_x(best_x), .best_y(best_y)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && last_point) state_next = ST_CHECK;
      ST_CHECK:  state_next = (count < CW'(MIN_HULL_POINTS)) ? ST_EMPTY : ST_SEEK;
      ST_EMPTY:  state_next = ST_IDLE;
      ST_SEEK:   if (match) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_RECORD;
      ST_RECORD: begin
        if (best_idx == start_idx || (k + 1'b1) >= CW'(MAX_POINTS)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SEEK;
        end
      end
      ST_EMIT:   if (emit_done) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load_shift  = 1'b0;
    rotate      = 1'b0;
    clear_cells = 1'b0;
    ectl        = '0;
    case (state)
      ST_IDLE:  load_shift = accept && (count < CW'(MAX_POINTS));
      ST_EMPTY: clear_cells = 1'b1;
      ST_DRAIN: clear_cells = 1'b1;
      ST_SEEK: begin
        rotate    = !match;
        ectl.init = match;
      end
      ST_SCAN: begin
        ectl.ph0 = (phase == 2'd0);
        ectl.ph1 = (phase == 2'd1);
        ectl.ph2 = (phase == 2'd2);
        rotate   = (phase == 2'd2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // point count, drop flag and running leftmost point
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (state == ST_EMPTY || state == ST_DRAIN) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (count < CW'(MAX_POINTS)) begin
        count <= count + 1'b1;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_shift &&
        (count == '0 || point_x < sx || (point_x == sx && point_y < sy))) begin
      start_idx <= IW'(count);
      sx        <= point_x;
      sy        <= point_y;
    end
  end

  // wrap bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      step   <= '0;
      k      <= '0;
      wrap   <= 1'b0;
      rd_ptr <= '0;
    end else begin
      case (state)
        ST_CHECK: begin
          cur    <= start_idx;
          ox     <= sx;
          oy     <= sy;
          target <= next_of_start;
          k      <= '0;
          wrap   <= 1'b0;
        end
        ST_SEEK: begin
          phase <= '0;
          step  <= '0;
        end
        ST_SCAN: begin
          if (phase == 2'd2) begin
            phase <= '0;
            step  <= step + 1'b1;
          end else begin
            phase <= phase + 1'b1;
          end
        end
        ST_RECORD: begin
          k      <= k + 1'b1;
          rd_ptr <= '0;
          if (best_idx != start_idx && (k + 1'b1) >= CW'(MAX_POINTS)) begin
            wrap <= 1'b1;
          end
          cur    <= best_idx;
          ox     <= best_x;
          oy     <= best_y;
          target <= next_of_best;
        end
        ST_EMIT:  rd_ptr <= rd_ptr + 1'b1;
        default: ;
      endcase
    end
  end

  // hull buffer write and registered read
  always_ff @(posedge clk) begin
    if (state == ST_RECORD) begin
      m_idx[IW'(k)] <= cur;
      m_x[IW'(k)]   <= ox;
      m_y[IW'(k)]   <= oy;
    end
    rd_idx <= m_idx[rd_ptr];
    rd_x   <= m_x[rd_ptr];
    rd_y   <= m_y[rd_ptr];
  end

  // result word flags
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_EMIT) || (state == ST_EMPTY);
    end
    last_r  <= (state == ST_EMPTY) || emit_done;
    empty_r <= (state == ST_EMPTY);
    ovf_r   <= (state != ST_EMPTY) && (dropped || wrap);
  end

  assign hull_x       = empty_r ? '0 : rd_x;
  assign hull_y       = empty_r ? '0 : rd_y;
  assign vertex_index = empty_r ? '0 : VIDX_W'(rd_idx);
  assign last_vertex  = last_r;
  assign empty_hull   = empty_r;
  assign overflow     = ovf_r;

  // checks
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_hull |-> last_vertex)
    else $error("empty result without last mark");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_vertex |=> !strobe)
    else $error("result word after last vertex");

  a_stream: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_vertex |=> strobe)
    else $error("gap inside hull stream");

  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_point |=> busy)
    else $error("closing word did not start the wrap");

endmodule
`default_nettype wire
